### src/scuc_pkg.sv
// Shared constants and types for the shader container unwrap checker.
package scuc_pkg;

  // Default width of the blob byte counter.
  localparam int LENGTH_BITS_DEFAULT = 32;

  // Magic words as they sit in the little-endian shift word.
  localparam logic [31:0] MAGIC_BARE    = 32'h4342_5844;
  localparam logic [31:0] MAGIC_BUNDLE  = 32'h4442_5355;

  // Layout constants of the three formats.
  localparam logic [31:0] MIN_CONTAINER = 32'd32;
  localparam logic [31:0] BUNDLE_HEAD   = 32'd8;
  localparam logic [31:0] WRAP_OFFSET   = 32'd38;
  localparam logic [31:0] TOTAL_AT      = 32'd24;
  localparam logic [31:0] LEN_FIELD     = 32'd4;
  localparam logic [7:0]  WRAP_FIRST    = 8'd2;

  // Reported format codes.
  localparam logic [1:0] FMT_NONE    = 2'd0;
  localparam logic [1:0] FMT_BARE    = 2'd1;
  localparam logic [1:0] FMT_WRAPPED = 2'd2;
  localparam logic [1:0] FMT_BUNDLE  = 2'd3;

  // Bundle parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER   = 6'b000001,
    PH_NAME_LEN = 6'b000010,
    PH_NAME     = 6'b000100,
    PH_PAY_LEN  = 6'b001000,
    PH_PAYLOAD  = 6'b010000,
    PH_DONE     = 6'b100000
  } phase_t;

endpackage

### src/scuc_in_if.sv
// Channel that carries one blob byte and its last-byte mark per word.
interface scuc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/scuc_out_if.sv
// Channel that carries one check result per word.
interface scuc_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  format_kind;
  logic [31:0] view_offset;
  logic [31:0] view_length;

  modport source (output valid, output found, output format_kind, output view_offset,
                  output view_length, input ready);
  modport sink   (input valid, input found, input format_kind, input view_offset,
                  input view_length, output ready);
endinterface

### src/shader_container_unwrap_check.sv
// Top level: streaming checker that locates a shader container inside a blob.
// Throughput: one byte per cycle while no last byte waits; the byte counter and three recognizers update in one step.
// A last byte waits in the input register only while an older result word is still unread.
// The last byte passes through the input register, and its result word is then held in the result register.
// Reset (rst, synchronous, active high) empties both registers and returns all
// recognizers to their start; they also return there after every last byte.
module shader_container_unwrap_check #(
  parameter int LENGTH_BITS = scuc_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  scuc_in_if.sink           blob,
  scuc_out_if.source        result
);

  localparam int SW = 33;
  localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] POS_MAGIC = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] POS_TOTAL = LENGTH_BITS'(scuc_pkg::TOTAL_AT + 32'd3);
  localparam logic [LENGTH_BITS-1:0] POS_COUNT = LENGTH_BITS'(scuc_pkg::BUNDLE_HEAD - 32'd1);
  localparam logic [LENGTH_BITS-1:0] POS_WMAGIC =
    LENGTH_BITS'(scuc_pkg::WRAP_OFFSET + 32'd3);
  localparam logic [LENGTH_BITS-1:0] POS_WTOTAL =
    LENGTH_BITS'(scuc_pkg::WRAP_OFFSET + scuc_pkg::TOTAL_AT + 32'd3);

  // Input register stage.
  logic       s1_valid;
  logic [7:0] s1_data;
  logic       s1_last;
  logic       s1_go;

  // Recognizer state.
  logic [LENGTH_BITS-1:0] byte_position;
  logic [31:0]            word_shift;
  logic                   bare_alive;
  logic [31:0]            bare_total;
  logic                   wrapped_alive;
  logic [31:0]            wrapped_total;
  logic                   bundle_alive;
  scuc_pkg::phase_t       bundle_phase;
  logic [31:0]            field_remaining;
  logic [31:0]            records_left;
  logic [LENGTH_BITS-1:0] payload_position;
  logic [31:0]            payload_size;
  logic [LENGTH_BITS-1:0] first_offset;
  logic [31:0]            first_length;

  logic [LENGTH_BITS-1:0] byte_position_next;
  logic [31:0]            word_shift_next;
  logic                   bare_alive_next;
  logic [31:0]            bare_total_next;
  logic                   wrapped_alive_next;
  logic [31:0]            wrapped_total_next;
  logic                   bundle_alive_next;
  scuc_pkg::phase_t       bundle_phase_next;
  logic [31:0]            field_remaining_next;
  logic [31:0]            records_left_next;
  logic [LENGTH_BITS-1:0] payload_position_next;
  logic [31:0]            payload_size_next;
  logic [LENGTH_BITS-1:0] first_offset_next;
  logic [31:0]            first_length_next;

  // Result computed from the state after the last byte.
  logic              res_found;
  logic [1:0]        res_kind;
  logic [31:0]       res_offset;
  logic [31:0]       res_length;
  logic [SW-1:0]     size_w;

  // The input stage moves on unless a last byte waits for a full result register.
  assign s1_go = s1_valid && (!s1_last || !result.valid || result.ready);
  assign blob.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (blob.ready) begin
      s1_valid <= blob.valid;
    end
    if (blob.valid && blob.ready) begin
      s1_data <= blob.data_byte;
      s1_last <= blob.last_byte;
    end
  end

  // Per-byte update of the counter and the three recognizers.
  always_comb begin
    logic [31:0]            fr_dec;
    logic [LENGTH_BITS-1:0] pp_inc;
    logic [31:0]            rl_dec;

    word_shift_next       = {s1_data, word_shift[31:8]};
    byte_position_next    = byte_position;
    bare_alive_next       = bare_alive;
    bare_total_next       = bare_total;
    wrapped_alive_next    = wrapped_alive;
    wrapped_total_next    = wrapped_total;
    bundle_alive_next     = bundle_alive;
    bundle_phase_next     = bundle_phase;
    field_remaining_next  = field_remaining;
    records_left_next     = records_left;
    payload_position_next = payload_position;
    payload_size_next     = payload_size;
    first_offset_next     = first_offset;
    first_length_next     = first_length;
    fr_dec                = field_remaining - 32'd1;
    pp_inc                = payload_position + LENGTH_BITS'(1);
    rl_dec                = records_left - 32'd1;

    if (byte_position == POS_MAX) begin
      // Blob too long for the counter: every recognizer fails.
      bare_alive_next    = 1'b0;
      wrapped_alive_next = 1'b0;
      bundle_alive_next  = 1'b0;
    end else begin
      byte_position_next = byte_position + LENGTH_BITS'(1);

      // Bare container.
      if (bare_alive) begin
        if (byte_position == POS_MAGIC && word_shift_next != scuc_pkg::MAGIC_BARE) begin
          bare_alive_next = 1'b0;
        end
        if (byte_position == POS_TOTAL) begin
          bare_total_next = word_shift_next;
          if (word_shift_next < scuc_pkg::MIN_CONTAINER) begin
            bare_alive_next = 1'b0;
          end
        end
      end

      // Wrapped program.
      if (wrapped_alive) begin
        if (byte_position == '0 && s1_data != scuc_pkg::WRAP_FIRST) begin
          wrapped_alive_next = 1'b0;
        end
        if (byte_position == POS_WMAGIC && word_shift_next != scuc_pkg::MAGIC_BARE) begin
          wrapped_alive_next = 1'b0;
        end
        if (byte_position == POS_WTOTAL) begin
          wrapped_total_next = word_shift_next;
        end
      end

      // Bundle record parser.
      if (bundle_alive) begin
        case (bundle_phase)
          scuc_pkg::PH_HEADER: begin
            if (byte_position == POS_MAGIC && word_shift_next != scuc_pkg::MAGIC_BUNDLE) begin
              bundle_alive_next = 1'b0;
            end else if (byte_position == POS_COUNT) begin
              if (word_shift_next == '0) begin
                bundle_alive_next = 1'b0;
              end else begin
                records_left_next    = word_shift_next;
                bundle_phase_next    = scuc_pkg::PH_NAME_LEN;
                field_remaining_next = scuc_pkg::LEN_FIELD;
              end
            end
          end
          scuc_pkg::PH_NAME_LEN: begin
            field_remaining_next = fr_dec;
            if (fr_dec == '0) begin
              if (word_shift_next == '0) begin
                bundle_alive_next = 1'b0;
              end else begin
                field_remaining_next = word_shift_next;
                bundle_phase_next    = scuc_pkg::PH_NAME;
              end
            end
          end
          scuc_pkg::PH_NAME: begin
            field_remaining_next = fr_dec;
            if (fr_dec == '0) begin
              field_remaining_next = scuc_pkg::LEN_FIELD;
              bundle_phase_next    = scuc_pkg::PH_PAY_LEN;
            end
          end
          scuc_pkg::PH_PAY_LEN: begin
            field_remaining_next = fr_dec;
            if (fr_dec == '0) begin
              if (word_shift_next < scuc_pkg::MIN_CONTAINER) begin
                bundle_alive_next = 1'b0;
              end else begin
                payload_size_next     = word_shift_next;
                payload_position_next = '0;
                bundle_phase_next     = scuc_pkg::PH_PAYLOAD;
                if (first_length == '0) begin
                  first_offset_next = byte_position + LENGTH_BITS'(1);
                  first_length_next = word_shift_next;
                end
              end
            end
          end
          scuc_pkg::PH_PAYLOAD: begin
            if (payload_position == POS_MAGIC && word_shift_next != scuc_pkg::MAGIC_BARE) begin
              bundle_alive_next = 1'b0;
            end else if (payload_position == POS_TOTAL && word_shift_next != payload_size) begin
              bundle_alive_next = 1'b0;
            end else begin
              payload_position_next = pp_inc;
              if (32'(pp_inc) == payload_size) begin
                records_left_next = rl_dec;
                if (rl_dec == '0) begin
                  bundle_phase_next = scuc_pkg::PH_DONE;
                end else begin
                  bundle_phase_next    = scuc_pkg::PH_NAME_LEN;
                  field_remaining_next = scuc_pkg::LEN_FIELD;
                end
              end
            end
          end
          default: begin
            // Bytes after the last record, or an unused phase code.
            bundle_alive_next = 1'b0;
          end
        endcase
      end
    end
  end

  // Verdict on the last byte: bare wins over wrapped, wrapped over bundle.
  always_comb begin
    size_w     = SW'(byte_position) + SW'(1);
    res_found  = 1'b0;
    res_kind   = scuc_pkg::FMT_NONE;
    res_offset = '0;
    res_length = '0;
    if (bare_alive_next && size_w >= SW'(scuc_pkg::MIN_CONTAINER) &&
        SW'(bare_total_next) <= size_w) begin
      res_found  = 1'b1;
      res_kind   = scuc_pkg::FMT_BARE;
      res_length = bare_total_next;
    end else if (wrapped_alive_next &&
                 size_w >= SW'(scuc_pkg::WRAP_OFFSET + scuc_pkg::MIN_CONTAINER) &&
                 SW'(wrapped_total_next) == size_w - SW'(scuc_pkg::WRAP_OFFSET)) begin
      res_found  = 1'b1;
      res_kind   = scuc_pkg::FMT_WRAPPED;
      res_offset = scuc_pkg::WRAP_OFFSET;
      res_length = wrapped_total_next;
    end else if (bundle_alive_next && bundle_phase_next == scuc_pkg::PH_DONE) begin
      res_found  = 1'b1;
      res_kind   = scuc_pkg::FMT_BUNDLE;
      res_offset = 32'(first_offset_next);
      res_length = first_length_next;
    end
  end

  // State registers; everything returns to its start after the last byte.
  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      byte_position    <= '0;
      word_shift       <= '0;
      bare_alive       <= 1'b1;
      bare_total       <= '0;
      wrapped_alive    <= 1'b1;
      wrapped_total    <= '0;
      bundle_alive     <= 1'b1;
      bundle_phase     <= scuc_pkg::PH_HEADER;
      field_remaining  <= '0;
      records_left     <= '0;
      payload_position <= '0;
      payload_size     <= '0;
      first_offset     <= '0;
      first_length     <= '0;
    end else if (s1_go) begin
      byte_position    <= byte_position_next;
      word_shift       <= word_shift_next;
      bare_alive       <= bare_alive_next;
      bare_total       <= bare_total_next;
      wrapped_alive    <= wrapped_alive_next;
      wrapped_total    <= wrapped_total_next;
      bundle_alive     <= bundle_alive_next;
      bundle_phase     <= bundle_phase_next;
      field_remaining  <= field_remaining_next;
      records_left     <= records_left_next;
      payload_position <= payload_position_next;
      payload_size     <= payload_size_next;
      first_offset     <= first_offset_next;
      first_length     <= first_length_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
    if (s1_go && s1_last) begin
      result.found       <= res_found;
      result.format_kind <= res_kind;
      result.view_offset <= res_offset;
      result.view_length <= res_length;
    end
  end

  // A result without a container carries no format, offset or length.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.found |->
      result.format_kind == scuc_pkg::FMT_NONE && result.view_offset == '0 &&
      result.view_length == '0)
    else $error("empty result carries a nonzero field");

  // A wrapped program always reports its fixed container offset.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.found && result.format_kind == scuc_pkg::FMT_WRAPPED |->
      result.view_offset == scuc_pkg::WRAP_OFFSET)
    else $error("wrapped result with wrong offset");

  // The recognizers restart after every last byte.
  assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> byte_position == '0 && bundle_phase == scuc_pkg::PH_HEADER)
    else $error("state not cleared after last byte");

  // A finished bundle has consumed all its records.
  assert property (@(posedge clk) disable iff (rst)
    bundle_alive && bundle_phase == scuc_pkg::PH_DONE |-> records_left == '0)
    else $error("bundle done with records left");

endmodule
